### hdl/mec_pkg.sv
// Shared types and constants for the mask equivalence canonicalizer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

    // Width of the raw specifier byte on the input channel.
    localparam int ByteWidth = 8;

    // Width of the mask presence set register.
    localparam int MaskWidth = 64;

    // Largest number of masks or candidates folded together in one stage.
    localparam int GroupSizeMax = 8;

    // Control that travels with every request down the pipeline.
    typedef struct packed {
        logic valid;
        logic out_of_range;
    } t_pipe_ctl;

endpackage

`default_nettype wire

### hdl/mask_equivalence_canonicalizer.sv
// Mask equivalence canonicalizer: maps each specifier byte to the smallest
// specifier with the same signature over the configured set of masks.
//
// Usage:
//   Input channel: i_valid / o_stall with payload i_spec_byte. A request is
//   taken at a rising edge where i_valid is high and o_stall is low.
//   Output channel: o_valid / i_stall with payload o_canonical_spec and
//   o_out_of_range. A request leaves at an edge where o_valid is high and
//   i_stall is low. Bytes of 2^SPEC_WIDTH or more give out_of_range = 1 and
//   a zero result.
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data into the mask presence
//   set; write it only while no request is in flight.
//   The four register stages (signature, per-group compare, group encode,
//   output) lie between acceptance and o_valid and load in that order.
//   Throughput is one request per cycle. Each stage holds only when it is
//   full and the stage after it holds, so bubbles close up and o_stall
//   rises only when the whole pipeline is full and the output is stalled.
//   Synchronous active-low reset empties the pipeline and clears the set.
`timescale 1ns / 1ps
`default_nettype none

module mask_equivalence_canonicalizer
    import mec_pkg::*;
#(
    parameter int SPEC_WIDTH = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [MaskWidth-1:0]  i_cfg_wr_data,
    input  wire logic                  i_valid,
    output      logic                  o_stall,
    input  wire logic [ByteWidth-1:0]  i_spec_byte,
    output      logic                  o_valid,
    input  wire logic                  i_stall,
    output      logic [SPEC_WIDTH-1:0] o_canonical_spec,
    output      logic                  o_out_of_range
);

    localparam int SpecCount  = 1 << SPEC_WIDTH;
    localparam int GroupSize  = (SpecCount < GroupSizeMax) ? SpecCount : GroupSizeMax;
    localparam int GroupCount = SpecCount / GroupSize;

    logic [MaskWidth-1:0]                  r_mask_present_set;
    logic [SpecCount-1:0]                  w_present;
    t_pipe_ctl                             w_ctl_sig;
    t_pipe_ctl                             w_ctl_match;
    logic [SpecCount-1:0]                  w_sig;
    logic [GroupCount-1:0]                 w_grp_hit;
    logic [GroupCount-1:0][SPEC_WIDTH-1:0] w_grp_idx;
    logic                                  w_match_stall;
    logic                                  w_encode_stall;

    // Mask presence set; only masks below 2^SPEC_WIDTH take part.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_present_set <= '0;
        end else if (i_cfg_wr_en) begin
            r_mask_present_set <= i_cfg_wr_data;
        end
    end

    assign w_present = r_mask_present_set[SpecCount-1:0];

    mec_signature #(
        .SPEC_WIDTH (SPEC_WIDTH)
    ) u_signature (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_spec_byte (i_spec_byte),
        .i_present   (w_present),
        .o_ctl       (w_ctl_sig),
        .o_sig       (w_sig),
        .i_stall     (w_match_stall)
    );

    mec_match #(
        .SPEC_WIDTH (SPEC_WIDTH)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl_sig),
        .o_stall   (w_match_stall),
        .i_sig     (w_sig),
        .i_present (w_present),
        .o_ctl     (w_ctl_match),
        .o_grp_hit (w_grp_hit),
        .o_grp_idx (w_grp_idx),
        .i_stall   (w_encode_stall)
    );

    mec_encode #(
        .SPEC_WIDTH (SPEC_WIDTH)
    ) u_encode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl_match),
        .o_stall          (w_encode_stall),
        .i_grp_hit        (w_grp_hit),
        .i_grp_idx        (w_grp_idx),
        .o_valid          (o_valid),
        .o_canonical_spec (o_canonical_spec),
        .o_out_of_range   (o_out_of_range),
        .i_stall          (i_stall)
    );

    // An out-of-range request always leaves with a zero result.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_canonical_spec == '0))
        else $error("out-of-range request with nonzero result");

    // With no mask present every specifier falls into the class of zero.
    a_empty_set_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (w_present == '0)) |-> (o_canonical_spec == '0))
        else $error("empty mask set gave nonzero result");

    // The input side only holds when every stage, the output too, is full.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && w_ctl_match.valid && w_ctl_sig.valid))
        else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire

### hdl/mec_signature.sv
// First pipeline stage: range check and signature of the input specifier.
// Depends on mec_pkg for the byte width and the pipeline control struct.
`timescale 1ns / 1ps
`default_nettype none

module mec_signature
    import mec_pkg::*;
#(
    parameter int SPEC_WIDTH = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire logic [ByteWidth-1:0]          i_spec_byte,
    input  wire logic [(1 << SPEC_WIDTH)-1:0]  i_present,
    output      t_pipe_ctl                     o_ctl,
    output      logic [(1 << SPEC_WIDTH)-1:0]  o_sig,
    input  wire logic                          i_stall
);

    localparam int SpecCount = 1 << SPEC_WIDTH;

    logic                 r_valid;
    logic                 r_oor;
    logic [SpecCount-1:0] r_sig;
    logic [SpecCount-1:0] n_sig;
    logic                 n_oor;
    logic [SPEC_WIDTH-1:0] w_spec;

    // The stage holds only while it has a request and the next one is stalled.
    assign o_stall = r_valid && i_stall;

    assign w_spec = i_spec_byte[SPEC_WIDTH-1:0];
    assign n_oor  = |i_spec_byte[ByteWidth-1:SPEC_WIDTH];

    // One signature bit per present mask: does the specifier touch it.
    always_comb begin
        for (int k = 0; k < SpecCount; k++) begin
            n_sig[k] = i_present[k] & (|(w_spec & SPEC_WIDTH'(k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_oor <= n_oor;
            r_sig <= n_sig;
        end
    end

    assign o_ctl.valid        = r_valid;
    assign o_ctl.out_of_range = r_oor;
    assign o_sig              = r_sig;

endmodule

`default_nettype wire

### hdl/mec_match.sv
// Second and third pipeline stages: compares the input signature with the
// signature of every candidate and finds the lowest match in each group.
// Depends on mec_pkg for the group size and the pipeline control struct.
`timescale 1ns / 1ps
`default_nettype none

module mec_match
    import mec_pkg::*;
#(
    parameter int SPEC_WIDTH = 6
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire t_pipe_ctl                                   i_ctl,
    output      logic                                        o_stall,
    input  wire logic [(1 << SPEC_WIDTH)-1:0]                i_sig,
    input  wire logic [(1 << SPEC_WIDTH)-1:0]                i_present,
    output      t_pipe_ctl                                   o_ctl,
    output      logic [((1 << SPEC_WIDTH) < GroupSizeMax ? 1 :
                        (1 << SPEC_WIDTH) / GroupSizeMax)-1:0] o_grp_hit,
    output      logic [((1 << SPEC_WIDTH) < GroupSizeMax ? 1 :
                        (1 << SPEC_WIDTH) / GroupSizeMax)-1:0]
                      [SPEC_WIDTH-1:0]                       o_grp_idx,
    input  wire logic                                        i_stall
);

    localparam int SpecCount  = 1 << SPEC_WIDTH;
    localparam int GroupSize  = (SpecCount < GroupSizeMax) ? SpecCount : GroupSizeMax;
    localparam int GroupCount = SpecCount / GroupSize;

    // Stage two registers: partial agreement of each candidate per mask group.
    logic                                   r2_valid;
    logic                                   r2_oor;
    logic [SpecCount-1:0][GroupCount-1:0]   r2_part;
    logic [SpecCount-1:0][GroupCount-1:0]   n2_part;
    logic                                   w2_stall;

    // Stage three registers: lowest matching candidate of each candidate group.
    logic                                   r3_valid;
    logic                                   r3_oor;
    logic [GroupCount-1:0]                  r3_hit;
    logic [GroupCount-1:0][SPEC_WIDTH-1:0]  r3_idx;
    logic [GroupCount-1:0]                  n3_hit;
    logic [GroupCount-1:0][SPEC_WIDTH-1:0]  n3_idx;
    logic                                   w3_stall;

    assign w3_stall = r3_valid && i_stall;
    assign w2_stall = r2_valid && w3_stall;
    assign o_stall  = w2_stall;

    // A candidate disagrees on a mask when the mask is present and the
    // candidate's touch bit differs from the input's signature bit.
    always_comb begin
        int  k;
        logic diff;
        for (int t = 0; t < SpecCount; t++) begin
            for (int g = 0; g < GroupCount; g++) begin
                n2_part[t][g] = 1'b1;
                for (int j = 0; j < GroupSize; j++) begin
                    k    = g * GroupSize + j;
                    diff = ((t & k) != 0) ^ i_sig[k];
                    if (i_present[k] && diff) begin
                        n2_part[t][g] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (!w2_stall) begin
            r2_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w2_stall) begin
            r2_oor  <= i_ctl.out_of_range;
            r2_part <= n2_part;
        end
    end

    // Within each group of candidates, keep the lowest one that matches fully.
    always_comb begin
        int t;
        for (int g = 0; g < GroupCount; g++) begin
            n3_hit[g] = 1'b0;
            n3_idx[g] = '0;
            for (int j = GroupSize - 1; j >= 0; j--) begin
                t = g * GroupSize + j;
                if (&r2_part[t]) begin
                    n3_hit[g] = 1'b1;
                    n3_idx[g] = SPEC_WIDTH'(t);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (!w3_stall) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w3_stall) begin
            r3_oor <= r2_oor;
            r3_hit <= n3_hit;
            r3_idx <= n3_idx;
        end
    end

    assign o_ctl.valid        = r3_valid;
    assign o_ctl.out_of_range = r3_oor;
    assign o_grp_hit          = r3_hit;
    assign o_grp_idx          = r3_idx;

endmodule

`default_nettype wire

### hdl/mec_encode.sv
// Final pipeline stage and output register: picks the lowest matching group
// and forces the result to zero for an out-of-range byte.
// Depends on mec_pkg for the group size and the pipeline control struct.
`timescale 1ns / 1ps
`default_nettype none

module mec_encode
    import mec_pkg::*;
#(
    parameter int SPEC_WIDTH = 6
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire t_pipe_ctl                                   i_ctl,
    output      logic                                        o_stall,
    input  wire logic [((1 << SPEC_WIDTH) < GroupSizeMax ? 1 :
                        (1 << SPEC_WIDTH) / GroupSizeMax)-1:0] i_grp_hit,
    input  wire logic [((1 << SPEC_WIDTH) < GroupSizeMax ? 1 :
                        (1 << SPEC_WIDTH) / GroupSizeMax)-1:0]
                      [SPEC_WIDTH-1:0]                       i_grp_idx,
    output      logic                                        o_valid,
    output      logic [SPEC_WIDTH-1:0]                       o_canonical_spec,
    output      logic                                        o_out_of_range,
    input  wire logic                                        i_stall
);

    localparam int SpecCount  = 1 << SPEC_WIDTH;
    localparam int GroupSize  = (SpecCount < GroupSizeMax) ? SpecCount : GroupSizeMax;
    localparam int GroupCount = SpecCount / GroupSize;

    logic                  r_valid;
    logic                  r_oor;
    logic [SPEC_WIDTH-1:0] r_canon;
    logic [SPEC_WIDTH-1:0] n_canon;

    assign o_stall = r_valid && i_stall;

    // Lowest group with a hit wins; the input itself always matches.
    always_comb begin
        n_canon = '0;
        for (int g = GroupCount - 1; g >= 0; g--) begin
            if (i_grp_hit[g]) begin
                n_canon = i_grp_idx[g];
            end
        end
        if (i_ctl.out_of_range) begin
            n_canon = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_oor   <= i_ctl.out_of_range;
            r_canon <= n_canon;
        end
    end

    assign o_valid          = r_valid;
    assign o_canonical_spec = r_canon;
    assign o_out_of_range   = r_oor;

endmodule

`default_nettype wire
